// ----- hw/rtl/bmmc_pkg.sv -----
// ============================================================================
// bmmc_pkg: shared types and constants for the bank mapped memory controller
// Access kinds, segment and I/O page decode points, FSM states and the
// layout of one result word.
// ============================================================================
package bmmc_pkg;

    localparam int WORK_RAM_DEPTH = 8192;
    localparam int RAM_AW         = $clog2(WORK_RAM_DEPTH);

    typedef enum logic [1:0] {
        ACT_MEM_RD  = 2'd0,
        ACT_MEM_WR  = 2'd1,
        ACT_SET_MAP = 2'd2,
        ACT_GET_MAP = 2'd3
    } bmmc_action_t;

    localparam logic [7:0] SEG_ROM_LAST    = 8'hF7;
    localparam logic [7:0] SEG_RAM_LAST    = 8'hFB;
    localparam logic [7:0] SEG_UNUSED_LAST = 8'hFE;

    localparam logic [12:0] IO_VIDEO_LAST   = 13'h03FF;
    localparam logic [12:0] IO_TIMER_RELOAD = 13'h0C00;
    localparam logic [12:0] IO_TIMER_CTRL   = 13'h0C01;
    localparam logic [12:0] IO_PAD_FIRST    = 13'h1000;
    localparam logic [12:0] IO_PAD_LAST     = 13'h13FF;
    localparam logic [12:0] IO_IRQ_MASK     = 13'h1402;
    localparam logic [12:0] IO_IRQ_TIMER    = 13'h1403;

    localparam logic [7:0] PAD_VALUE = 8'hBF;
    localparam logic [7:0] OPEN_BUS  = 8'hFF;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_DONE  = 2'd2
    } bmmc_state_t;

    // last member sits in the lowest bits
    typedef struct packed {
        logic        rom_write_fault;
        logic        timer_irq_request;
        logic [7:0]  video_data;
        logic [1:0]  video_port;
        logic        video_is_write;
        logic        video_access;
        logic [20:0] rom_address;
        logic        rom_read;
        logic [7:0]  read_data;
    } bmmc_result_t;

    typedef struct packed {
        logic accept;
        logic load_out;
        logic clear;
    } bmmc_cmd_t;

    typedef struct packed {
        logic clear_last;
    } bmmc_status_t;

endpackage

// ----- hw/rtl/bank_mapped_memory_controller.sv -----
// ============================================================================
// bank_mapped_memory_controller: bank switched memory access controller
// Maps 16-bit logical accesses through eight mapping registers onto ROM,
// work RAM, and the I/O page, one result word per access word.
//
// channel  dir  tdata (low bit up)                                 tuser
// s_       in   logical_addr[15:0] write_data[23:16] mpr_slot[26:24] action[1:0]
// m_       out  read_data rom_read rom_address video_access          -
//               video_is_write video_port video_data
//               timer_irq_request rom_write_fault (44 bits)
//
// Each word is accepted with its RAM read, then its result is loaded.
// After reset the work RAM is cleared, s_tready low.
// s_tready is high only when no word is in flight; a held result in the
// output register does not block the next accept, only the next load.
// ============================================================================
module bank_mapped_memory_controller
    import bmmc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // logical_addr, write_data, mpr_slot, pad
    input  logic [1:0]  s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // read_data .. rom_write_fault, pad
);

    bmmc_cmd_t    cmd;
    bmmc_status_t status;
    bmmc_result_t result;

    bmmc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bmmc_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .action       (s_tuser),
        .logical_addr (s_tdata[15:0]),
        .write_data   (s_tdata[23:16]),
        .mpr_slot     (s_tdata[26:24]),
        .result       (result)
    );

    assign m_tdata = {4'd0, result};

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("accept while a word is in flight");

    a_load_safe: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("result overwritten before it was taken");

    a_rom_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(result.rom_read && result.rom_write_fault))
        else $error("rom read and rom write fault together");

    a_video_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && result.video_is_write) |-> result.video_access)
        else $error("video write without video access");

endmodule

// ----- hw/rtl/bmmc_ctrl.sv -----
// ============================================================================
// bmmc_ctrl: sequencing for the bank mapped memory controller
// Runs the work RAM clear after reset, takes one word at a time and owns
// the result valid flag.
// ============================================================================
module bmmc_ctrl
    import bmmc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  bmmc_status_t status,
    output bmmc_cmd_t    cmd
);

    bmmc_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;

endmodule

// ----- hw/rtl/bmmc_datapath.sv -----
// ============================================================================
// bmmc_datapath: mapping, decode, work RAM and I/O page registers
// Decodes an accepted word, applies its writes, and holds the result until
// it is moved into the output register.
// ============================================================================
module bmmc_datapath
    import bmmc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  bmmc_cmd_t    cmd,
    output bmmc_status_t status,
    input  logic [1:0]   action,
    input  logic [15:0]  logical_addr,
    input  logic [7:0]   write_data,
    input  logic [2:0]   mpr_slot,
    output bmmc_result_t result
);

    logic [7:0]        map_reg [8];
    logic [6:0]        timer_reload_reg;
    logic              timer_on_reg;
    logic [7:0]        irq_mask_reg;
    logic [RAM_AW-1:0] clr_addr_reg;

    logic [7:0]        work_ram [WORK_RAM_DEPTH];
    logic [7:0]        ram_rdata_reg;

    bmmc_result_t      pend_reg;
    logic              use_ram_reg;
    bmmc_result_t      out_reg;
    bmmc_result_t      load_val;

    bmmc_action_t      act;
    logic [2:0]        map_idx;
    logic [7:0]        map_val;
    logic [7:0]        seg;
    logic [12:0]       off;
    logic [RAM_AW-1:0] ram_idx;
    bmmc_result_t      res;
    logic              use_ram;
    logic              wr_map, wr_ram, wr_reload, wr_on, wr_mask;

    assign act     = bmmc_action_t'(action);
    assign map_idx = (act == ACT_SET_MAP || act == ACT_GET_MAP) ? mpr_slot
                                                                : logical_addr[15:13];
    assign map_val = map_reg[map_idx];
    assign seg     = map_val;
    assign off     = logical_addr[12:0];
    assign ram_idx = RAM_AW'(off);

    always_comb begin
        res       = '0;
        use_ram   = 1'b0;
        wr_map    = 1'b0;
        wr_ram    = 1'b0;
        wr_reload = 1'b0;
        wr_on     = 1'b0;
        wr_mask   = 1'b0;
        case (act)
            ACT_SET_MAP: begin
                wr_map = 1'b1;
            end
            ACT_GET_MAP: begin
                res.read_data = map_val;
            end
            ACT_MEM_RD: begin
                if (seg <= SEG_ROM_LAST) begin
                    res.read_data   = OPEN_BUS;
                    res.rom_read    = 1'b1;
                    res.rom_address = {seg, off};
                end else if (seg <= SEG_RAM_LAST) begin
                    use_ram = 1'b1;
                end else if (seg <= SEG_UNUSED_LAST) begin
                    res.read_data = OPEN_BUS;
                end else if (off <= IO_VIDEO_LAST) begin
                    res.read_data    = OPEN_BUS;
                    res.video_access = 1'b1;
                    res.video_port   = off[1:0];
                end else if (off == IO_TIMER_RELOAD) begin
                    res.read_data = {1'b0, timer_reload_reg};
                end else if (off == IO_TIMER_CTRL) begin
                    res.read_data = {7'd0, timer_on_reg};
                end else if (off inside {[IO_PAD_FIRST:IO_PAD_LAST]}) begin
                    res.read_data = PAD_VALUE;
                end else if (off == IO_IRQ_MASK) begin
                    res.read_data = irq_mask_reg;
                end else begin
                    res.read_data = OPEN_BUS;
                end
            end
            ACT_MEM_WR: begin
                if (seg <= SEG_ROM_LAST) begin
                    res.rom_write_fault = 1'b1;
                end else if (seg <= SEG_RAM_LAST) begin
                    wr_ram = 1'b1;
                end else if (seg <= SEG_UNUSED_LAST) begin
                    res = '0;
                end else if (off <= IO_VIDEO_LAST) begin
                    res.video_access   = 1'b1;
                    res.video_is_write = 1'b1;
                    res.video_port     = off[1:0];
                    res.video_data     = write_data;
                end else if (off == IO_TIMER_RELOAD) begin
                    wr_reload = 1'b1;
                end else if (off == IO_TIMER_CTRL) begin
                    wr_on = 1'b1;
                end else if (off == IO_IRQ_MASK) begin
                    wr_mask = 1'b1;
                end else if (off == IO_IRQ_TIMER) begin
                    res.timer_irq_request = 1'b1;
                end
            end
            default: begin
                res = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                map_reg[i] <= '0;
            end
            timer_reload_reg <= '0;
            timer_on_reg     <= 1'b0;
            irq_mask_reg     <= '0;
            clr_addr_reg     <= '0;
        end else begin
            if (cmd.clear) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.accept && wr_map) begin
                map_reg[mpr_slot] <= write_data;
            end
            if (cmd.accept && wr_reload) begin
                timer_reload_reg <= write_data[6:0];
            end
            if (cmd.accept && wr_on) begin
                timer_on_reg <= write_data[0];
            end
            if (cmd.accept && wr_mask) begin
                irq_mask_reg <= write_data;
            end
        end
    end

    assign status.clear_last = (clr_addr_reg == RAM_AW'(WORK_RAM_DEPTH - 1));

    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            work_ram[clr_addr_reg] <= '0;
        end else if (cmd.accept && wr_ram) begin
            work_ram[ram_idx] <= write_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            ram_rdata_reg <= work_ram[ram_idx];
        end
    end

    always_comb begin
        load_val = pend_reg;
        if (use_ram_reg) begin
            load_val.read_data = ram_rdata_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            pend_reg    <= res;
            use_ram_reg <= use_ram;
        end
        if (cmd.load_out) begin
            out_reg <= load_val;
        end
    end

    assign result = out_reg;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ============================================================================
// testbench: bank mapped memory controller access check
// Drives access words on the input stream and predicts each result word from
// a private copy of the mapping registers, work RAM and I/O page registers.
// A short directed run covers the segment kinds and I/O page decode points.
// Random words follow, biased toward I/O page mappings. Both stream
// sides idle at random in changing proportions.
// ============================================================================
import bmmc_pkg::*;

class access_scoreboard;
    logic [7:0]   map_regs [8];
    logic [7:0]   work_ram [WORK_RAM_DEPTH];
    logic [6:0]   timer_reload;
    logic         timer_on;
    logic [7:0]   irq_mask;
    bmmc_result_t expected_q [$];
    int unsigned  mismatches;
    int unsigned  words_checked;
    int unsigned  rom_reads;
    int unsigned  rom_faults;
    int unsigned  video_hits;
    int unsigned  irq_pulses;

    function new();
        foreach (map_regs[i]) map_regs[i] = 8'h00;
        foreach (work_ram[i]) work_ram[i] = 8'h00;
        timer_reload  = 7'h00;
        timer_on      = 1'b0;
        irq_mask      = 8'h00;
        mismatches    = 0;
        words_checked = 0;
        rom_reads     = 0;
        rom_faults    = 0;
        video_hits    = 0;
        irq_pulses    = 0;
    endfunction

    function bmmc_result_t predict_access(bmmc_action_t act, logic [15:0] addr,
                                          logic [7:0] data, logic [2:0] slot);
        bmmc_result_t r;
        logic [7:0]   seg;
        logic [12:0]  off;
        int           ram_idx;
        r       = '0;
        seg     = map_regs[addr[15:13]];
        off     = addr[12:0];
        ram_idx = off % WORK_RAM_DEPTH;
        case (act)
            ACT_SET_MAP: map_regs[slot] = data;
            ACT_GET_MAP: r.read_data = map_regs[slot];
            ACT_MEM_RD: begin
                if (seg <= SEG_ROM_LAST) begin
                    r.read_data   = OPEN_BUS;
                    r.rom_read    = 1'b1;
                    r.rom_address = {seg, off};
                end else if (seg <= SEG_RAM_LAST) begin
                    r.read_data = work_ram[ram_idx];
                end else if (seg <= SEG_UNUSED_LAST) begin
                    r.read_data = OPEN_BUS;
                end else if (off <= IO_VIDEO_LAST) begin
                    r.read_data    = OPEN_BUS;
                    r.video_access = 1'b1;
                    r.video_port   = off[1:0];
                end else if (off == IO_TIMER_RELOAD) begin
                    r.read_data = {1'b0, timer_reload};
                end else if (off == IO_TIMER_CTRL) begin
                    r.read_data = {7'b0, timer_on};
                end else if (off >= IO_PAD_FIRST && off <= IO_PAD_LAST) begin
                    r.read_data = PAD_VALUE;
                end else if (off == IO_IRQ_MASK) begin
                    r.read_data = irq_mask;
                end else begin
                    r.read_data = OPEN_BUS;
                end
            end
            ACT_MEM_WR: begin
                if (seg <= SEG_ROM_LAST) begin
                    r.rom_write_fault = 1'b1;
                end else if (seg <= SEG_RAM_LAST) begin
                    work_ram[ram_idx] = data;
                end else if (seg > SEG_UNUSED_LAST) begin
                    if (off <= IO_VIDEO_LAST) begin
                        r.video_access   = 1'b1;
                        r.video_is_write = 1'b1;
                        r.video_port     = off[1:0];
                        r.video_data     = data;
                    end else if (off == IO_TIMER_RELOAD) begin
                        timer_reload = data[6:0];
                    end else if (off == IO_TIMER_CTRL) begin
                        timer_on = data[0];
                    end else if (off == IO_IRQ_MASK) begin
                        irq_mask = data;
                    end else if (off == IO_IRQ_TIMER) begin
                        r.timer_irq_request = 1'b1;
                    end
                end
            end
        endcase
        rom_reads  += r.rom_read;
        rom_faults += r.rom_write_fault;
        video_hits += r.video_access;
        irq_pulses += r.timer_irq_request;
        return r;
    endfunction

    function void note_access(bmmc_action_t act, logic [15:0] addr,
                              logic [7:0] data, logic [2:0] slot);
        expected_q.push_back(predict_access(act, addr, data, slot));
    endfunction

    function void compare_field(string name, logic [20:0] exp, logic [20:0] act);
        if (exp !== act) begin
            $error("%s expected %0h actual %0h", name, exp, act);
            mismatches++;
        end
    endfunction

    function void check_result(bmmc_result_t got);
        bmmc_result_t exp;
        if (expected_q.size() == 0) begin
            $error("result word with no access pending");
            mismatches++;
            return;
        end
        exp = expected_q.pop_front();
        words_checked++;
        compare_field("read_data", 21'(exp.read_data), 21'(got.read_data));
        compare_field("rom_read", 21'(exp.rom_read), 21'(got.rom_read));
        compare_field("rom_address", exp.rom_address, got.rom_address);
        compare_field("video_access", 21'(exp.video_access), 21'(got.video_access));
        compare_field("video_is_write", 21'(exp.video_is_write),
                      21'(got.video_is_write));
        compare_field("video_port", 21'(exp.video_port), 21'(got.video_port));
        compare_field("video_data", 21'(exp.video_data), 21'(got.video_data));
        compare_field("timer_irq_request", 21'(exp.timer_irq_request),
                      21'(got.timer_irq_request));
        compare_field("rom_write_fault", 21'(exp.rom_write_fault),
                      21'(got.rom_write_fault));
    endfunction
endclass

module testbench;

    localparam int WATCHDOG_LIMIT = 50000;
    localparam int RANDOM_PER_PHASE = 310;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = ACT_MEM_RD;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    int unsigned src_idle_pct   = 32;
    int unsigned sink_stall_pct = 56;
    int unsigned idle_cycles    = 0;

    access_scoreboard sb = new();

    bank_mapped_memory_controller i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(bmmc_result_t'(m_tdata[$bits(bmmc_result_t)-1:0]));
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved in %0d cycles", WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_access(bmmc_action_t act, logic [15:0] addr,
                               logic [7:0] data, logic [2:0] slot);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, slot, data, addr};
        s_tuser  <= act;
        do @(posedge aclk); while (!s_tready);
        sb.note_access(act, addr, data, slot);
    endtask

    // favours I/O page mappings, mostly I/O decode points
    task automatic send_random_access();
        bmmc_action_t act;
        logic [15:0]  addr;
        logic [7:0]   data;
        logic [2:0]   slot;
        int           pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            act = ACT_SET_MAP;
        else if (pick < 25)
            act = ACT_GET_MAP;
        else if (pick < 62)
            act = ACT_MEM_RD;
        else
            act = ACT_MEM_WR;
        addr = 16'($urandom);
        data = 8'($urandom);
        slot = 3'($urandom);
        if (act == ACT_SET_MAP) begin
            case ($urandom_range(0, 5))
                0: ;
                1: data = 8'hF8 + 8'($urandom_range(0, 3));
                2, 3: data = 8'hFF;
                4: data = 8'hFC + 8'($urandom_range(0, 2));
                default: data = 8'($urandom_range(0, SEG_ROM_LAST));
            endcase
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2: ;
                3: addr[12:0] = 13'($urandom_range(0, IO_VIDEO_LAST));
                4: addr[12:0] = IO_TIMER_RELOAD + 13'($urandom_range(0, 1));
                5: addr[12:0] = 13'($urandom_range(IO_TIMER_RELOAD, 13'h0FFF));
                6: addr[12:0] = 13'($urandom_range(IO_PAD_FIRST, IO_PAD_LAST));
                7: addr[12:0] = 13'h1400 + 13'($urandom_range(0, 3));
                8: addr[12:0] = 13'($urandom_range(0, 15));
                default: addr[12:0] = 13'h1FF0 + 13'($urandom_range(0, 15));
            endcase
        end
        send_access(act, addr, data, slot);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        send_access(ACT_GET_MAP, 16'h0000, 8'h00, 3'd0);
        send_access(ACT_GET_MAP, 16'hFFFF, 8'hFF, 3'd7);
        send_access(ACT_MEM_RD,  16'h0000, 8'h00, 3'd0);
        send_access(ACT_MEM_WR,  16'hFFFF, 8'h55, 3'd7);
        send_access(ACT_SET_MAP, 16'h0000, SEG_ROM_LAST, 3'd7);
        send_access(ACT_MEM_RD,  16'hFFFF, 8'h00, 3'd0);
        send_access(ACT_SET_MAP, 16'h0000, 8'hF8, 3'd1);
        send_access(ACT_MEM_WR,  16'h3FFF, 8'hA5, 3'd0);
        send_access(ACT_SET_MAP, 16'h0000, SEG_RAM_LAST, 3'd2);
        send_access(ACT_MEM_RD,  16'h5FFF, 8'h00, 3'd0);
        send_access(ACT_SET_MAP, 16'h0000, SEG_UNUSED_LAST, 3'd3);
        send_access(ACT_MEM_WR,  16'h6000, 8'h12, 3'd0);
        send_access(ACT_MEM_RD,  16'h7FFF, 8'h00, 3'd0);
        send_access(ACT_SET_MAP, 16'h0000, 8'hFF, 3'd4);
        send_access(ACT_MEM_WR,  16'h83FF, 8'h5A, 3'd0);
        send_access(ACT_MEM_RD,  16'h8000, 8'h00, 3'd0);
        send_access(ACT_MEM_WR,  16'h8C00, 8'hFF, 3'd0);
        send_access(ACT_MEM_WR,  16'h8C01, 8'hFF, 3'd0);
        send_access(ACT_MEM_RD,  16'h8C00, 8'h00, 3'd0);
        send_access(ACT_MEM_RD,  16'h9000, 8'h00, 3'd0);
        send_access(ACT_MEM_WR,  16'h9402, 8'hFF, 3'd0);
        send_access(ACT_MEM_RD,  16'h9402, 8'h00, 3'd0);
        send_access(ACT_MEM_WR,  16'h9403, 8'h01, 3'd0);
        send_access(ACT_MEM_RD,  16'h9403, 8'h00, 3'd0);
        send_access(ACT_GET_MAP, 16'h0000, 8'h00, 3'd4);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct   = 32;
                    sink_stall_pct = 56;
                end
                1: begin
                    src_idle_pct   = 56;
                    sink_stall_pct = 32;
                end
                default: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
            endcase
            repeat (RANDOM_PER_PHASE) send_random_access();
        end
        s_tvalid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Checked %0d result words: %0d ROM reads, %0d ROM write faults,",
                 sb.words_checked, sb.rom_reads, sb.rom_faults);
        $display("%0d video forwards and %0d timer interrupt pulses.",
                 sb.video_hits, sb.irq_pulses);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/bmmc_pkg.sv
hw/rtl/bmmc_ctrl.sv
hw/rtl/bmmc_datapath.sv
hw/rtl/bank_mapped_memory_controller.sv
test/testbench.sv
